FILE: rtl/core/ect_pkg.sv
// Shared types and constants for the expression character tokenizer.
package ect_pkg;

  localparam int unsigned DefMaxLen  = 4096;
  localparam int unsigned CharW      = 8;
  localparam int unsigned TokStartW  = 12;
  localparam int unsigned TokLenW    = 13;
  localparam int unsigned ResPerItem = 3;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned OutDataW   = 40;

  localparam logic [CharW-1:0] CharLParen = 8'h28;
  localparam logic [CharW-1:0] CharRParen = 8'h29;
  localparam logic [CharW-1:0] CharComma  = 8'h2C;
  localparam logic [CharW-1:0] CharDot    = 8'h2E;
  localparam logic [CharW-1:0] CharPlus   = 8'h2B;
  localparam logic [CharW-1:0] CharMinus  = 8'h2D;
  localparam logic [CharW-1:0] CharStar   = 8'h2A;
  localparam logic [CharW-1:0] CharSlash  = 8'h2F;
  localparam logic [CharW-1:0] CharCaret  = 8'h5E;
  localparam logic [CharW-1:0] CharBang   = 8'h21;
  localparam logic [CharW-1:0] CharSpace  = 8'h20;

  typedef enum logic [2:0] {
    TokWord     = 3'd0,
    TokNumber   = 3'd1,
    TokLParen   = 3'd2,
    TokRParen   = 3'd3,
    TokComma    = 3'd4,
    TokOperator = 3'd5,
    TokError    = 3'd6,
    TokEnd      = 3'd7
  } tok_kind_e;

  // pending run, one-hot
  typedef enum logic [2:0] {
    RunNone   = 3'b001,
    RunWord   = 3'b010,
    RunNumber = 3'b100
  } run_kind_e;

  typedef struct packed {
    tok_kind_e              kind;
    logic [CharW-1:0]       sym;
    logic [TokStartW-1:0]   start;
    logic [TokLenW-1:0]     len;
  } tok_t;

  // results of one input beat, compacted from index 0; cnt is 1..3
  typedef struct packed {
    logic [1:0]                 cnt;
    tok_t [ResPerItem-1:0]      res;
  } bundle_t;

endpackage

FILE: rtl/core/ect_front.sv
// Front end: classifies each character, tracks the pending run, builds result bundles.
module ect_front import ect_pkg::*; #(
  parameter int unsigned MaxLen = DefMaxLen
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [CharW-1:0] char_i,
  input  logic             last_i,
  output logic             push_o,
  output bundle_t          bundle_o
);

  localparam int unsigned PosW = $clog2(MaxLen + 1);
  localparam logic [PosW-1:0] PosLimit = PosW'(MaxLen);
  localparam logic [PosW-1:0] PosSat   = PosW'(MaxLen - 1);

  run_kind_e       run_q, run_d;
  logic [PosW-1:0] start_q, start_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            drop_q, drop_d;

  run_kind_e cls;
  logic      simple;
  logic      va, vb, vc;
  tok_t      tok_a, tok_b, tok_c, tok_d, tok_bc;
  logic      vbc;
  logic [1:0] cnt;

  always_comb begin
    if (char_i inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
      cls = RunWord;
    end else if (char_i inside {[8'h30:8'h39]}) begin
      cls = RunNumber;
    end else begin
      cls = RunNone;
    end
    simple = char_i inside {CharLParen, CharRParen, CharComma, CharDot, CharPlus,
                            CharMinus, CharStar, CharSlash, CharCaret, CharBang,
                            CharSpace};
  end

  always_comb begin
    run_d   = run_q;
    start_d = start_q;
    pos_d   = pos_q;
    drop_d  = drop_q;
    va      = 1'b0;
    vb      = 1'b0;
    vc      = 1'b0;
    tok_a   = '0;
    tok_b   = '0;
    tok_c   = '0;
    tok_d   = '0;
    tok_d.kind = TokEnd;

    if (!drop_q) begin
      if (pos_q >= PosLimit) begin
        run_d  = RunNone;
        drop_d = 1'b1;
        va     = 1'b1;
        tok_a  = '{kind: TokError, sym: char_i, start: TokStartW'(PosSat),
                   len: TokLenW'(1)};
      end else if (cls == RunNone && !simple) begin
        run_d  = RunNone;
        drop_d = 1'b1;
        va     = 1'b1;
        tok_a  = '{kind: TokError, sym: char_i, start: TokStartW'(pos_q),
                   len: TokLenW'(1)};
      end else begin
        if (run_q != cls && run_q != RunNone) begin
          va    = 1'b1;
          tok_a = '{kind: (run_q == RunWord) ? TokWord : TokNumber, sym: '0,
                    start: TokStartW'(start_q), len: TokLenW'(pos_q - start_q)};
          run_d = RunNone;
        end
        if (cls != RunNone) begin
          if (run_d == RunNone) begin
            run_d   = cls;
            start_d = pos_q;
          end
        end else if (char_i != CharSpace) begin
          vb          = 1'b1;
          tok_b.sym   = char_i;
          tok_b.start = TokStartW'(pos_q);
          tok_b.len   = TokLenW'(1);
          case (char_i)
            CharLParen: tok_b.kind = TokLParen;
            CharRParen: tok_b.kind = TokRParen;
            CharComma:  tok_b.kind = TokComma;
            default:    tok_b.kind = TokOperator;
          endcase
        end
        pos_d = pos_q + PosW'(1);
      end
    end

    if (last_i) begin
      // flush uses the position after this character
      if (!drop_d && run_d != RunNone) begin
        vc    = 1'b1;
        tok_c = '{kind: (run_d == RunWord) ? TokWord : TokNumber, sym: '0,
                  start: TokStartW'(start_d), len: TokLenW'(pos_d - start_d)};
      end
      run_d   = RunNone;
      start_d = '0;
      pos_d   = '0;
      drop_d  = 1'b0;
    end
  end

  // a single-char token clears the run, so b and c never both fire
  always_comb begin
    vbc    = vb | vc;
    tok_bc = vb ? tok_b : tok_c;
    cnt    = {1'b0, va} + {1'b0, vbc} + {1'b0, last_i};
    bundle_o.cnt    = cnt;
    bundle_o.res[0] = va ? tok_a : (vbc ? tok_bc : tok_d);
    bundle_o.res[1] = (va && vbc) ? tok_bc : tok_d;
    bundle_o.res[2] = tok_d;
    push_o          = accept_i && (cnt != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= RunNone;
      start_q <= '0;
      pos_q   <= '0;
      drop_q  <= 1'b0;
    end else if (accept_i) begin
      run_q   <= run_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      drop_q  <= drop_d;
    end
  end

endmodule

FILE: rtl/core/ect_queue.sv
// Small bundle queue between the front and back ends.
module ect_queue import ect_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  output logic    valid_o,
  output bundle_t head_o,
  input  logic    pop_i
);

  bundle_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_q, rd_q;
  logic [QueuePtrW:0]    cnt_q;

  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QueuePtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QueuePtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QueuePtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/core/ect_back.sv
// Back end: walks the head bundle one token per beat into the output register.
module ect_back import ect_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  bundle_t q_head_i,
  output logic    q_pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output tok_t    out_tok_o,
  output logic    out_final_o
);

  logic       out_valid_q, out_valid_d;
  tok_t       out_tok_q;
  logic       out_final_q;
  logic [1:0] sub_q, sub_d;
  logic       load, is_final;
  tok_t       sel_tok;

  always_comb begin
    case (sub_q)
      2'd0:    sel_tok = q_head_i.res[0];
      2'd1:    sel_tok = q_head_i.res[1];
      default: sel_tok = q_head_i.res[2];
    endcase
    load     = q_valid_i && (!out_valid_q || out_ready_i);
    is_final = (sub_q == (q_head_i.cnt - 2'd1));
    q_pop_o  = load && is_final;
    sub_d    = sub_q;
    if (load) begin
      sub_d = is_final ? 2'd0 : sub_q + 2'd1;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_tok_q   <= sel_tok;
      out_final_q <= is_final;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q       <= sub_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tok_o   = out_tok_q;
  assign out_final_o = out_final_q;

endmodule

FILE: rtl/core/expression_char_tokenizer.sv
// Top level of the expression character tokenizer.
//
//  channel  dir  tdata                              tuser       tlast
//  s_axis   in   [7:0] char_code                    -           last_char
//  m_axis   out  [7:0] symbol, [19:8] token_start,  token_kind  final_of_item
//                [32:20] token_length, rest zero
//
// One character is taken per cycle while the queue is not full; each token
// leaves one per cycle when the output is not stalled. The first token passes
// the bundle queue and then the output register. Throughput is set by the
// output port: the four-deep bundle queue absorbs bursts and backs up the input
// when full. Reset is asynchronous, active low; no clearing pass is needed.
module expression_char_tokenizer import ect_pkg::*; #(
  parameter int unsigned MaxLen = DefMaxLen
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [CharW-1:0]     s_axis_tdata,   // [7:0] char_code
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,   // [7:0] symbol, [19:8] start, [32:20] length
  output logic [2:0]           m_axis_tuser,   // [2:0] token_kind
  output logic                 m_axis_tlast
);

  logic    accept, push, q_full, q_valid, q_pop;
  bundle_t push_bundle, head_bundle;
  tok_t    out_tok;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ect_front #(.MaxLen(MaxLen)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .push_o   (push),
    .bundle_o (push_bundle)
  );

  ect_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head_bundle),
    .pop_i       (q_pop)
  );

  ect_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head_bundle),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tok_o   (out_tok),
    .out_final_o (m_axis_tlast)
  );

  assign m_axis_tuser = out_tok.kind;
  assign m_axis_tdata = {(OutDataW-CharW-TokStartW-TokLenW)'(0),
                         out_tok.len, out_tok.start, out_tok.sym};

endmodule

FILE: rtl/core/ect_checker.sv
// Port-level checks for the tokenizer, bound to the top level.
module ect_checker import ect_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [2:0]          m_axis_tuser,
  input logic                m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_end_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == TokEnd |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("end token not last or not empty");

  a_single_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == TokLParen || m_axis_tuser == TokRParen ||
      m_axis_tuser == TokComma || m_axis_tuser == TokOperator ||
      m_axis_tuser == TokError) |-> m_axis_tdata[32:20] == 13'd1)
    else $error("single-char token length not one");

  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == TokWord || m_axis_tuser == TokNumber) |->
      m_axis_tdata[32:20] != 13'd0 && m_axis_tdata[7:0] == 8'd0)
    else $error("run token empty or carries a symbol");

endmodule

bind expression_char_tokenizer ect_checker u_ect_checker (.*);
